// ===== rtl/core/pret_pkg.sv =====
package pret_pkg;

   // channel store
   localparam int CHANNELS = 8;
   localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   // field widths
   localparam int CHAN_W     = 3;
   localparam int FLAGS_W    = 4;
   localparam int POWER_W    = 32;
   localparam int THRESH_W   = 31;
   localparam int HOLD_W     = 8;
   localparam int PHASES     = 4;
   localparam int PHASE_W    = 2;
   localparam int REQ_DATA_W = 136;
   localparam int RSP_DATA_W = 8;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // register reset values and indexes
   localparam logic [THRESH_W-1:0] THRESH_RESET  = 31'd40;
   localparam logic [HOLD_W-1:0]   HOLD_RESET    = 8'd60;
   localparam logic                REG_THRESHOLD = 1'b0;
   localparam logic                REG_HOLD      = 1'b1;

   // event codes
   localparam logic [PHASE_W-1:0] PHASE_TOTAL = 2'd3;
   localparam logic               KIND_PHASE  = 1'b0;
   localparam logic               KIND_TOTAL  = 1'b1;

   // event group queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // one stored channel entry
   typedef struct packed {
      logic [PHASES-1:0][HOLD_W-1:0] timer;
      logic [FLAGS_W-1:0]            prev;
   } pret_entry_type;

   // events caused by one sample
   typedef struct packed {
      logic [CHAN_W-1:0]  channel;
      logic [FLAGS_W-1:0] flags;
      logic [PHASES-1:0]  fire;
   } pret_group_type;

   // lowest set phase of a fire mask
   function automatic logic [PHASE_W-1:0] first_phase(input logic [PHASES-1:0] m);
      logic [PHASE_W-1:0] r;
      r = '0;
      for (int i = PHASES - 1; i >= 0; i--) begin
         if (m[i]) begin
            r = PHASE_W'(i);
         end
      end
      return r;
   endfunction

endpackage

// ===== rtl/core/power_reversal_event_timer.sv =====
// Power reversal event timer. Each input word is one per-second sample of a
// metering channel (channel in tuser): four direction flags and four signed
// powers. A direction change whose power magnitude exceeds the threshold
// register loads that phase's hold timer with hold_ticks; all running timers
// of the channel then count down, and each one that reaches zero produces a
// result word (phase A, B, C, then total; tlast marks the last one of a
// sample). The block takes one input word per cycle unless held off. Channel
// state sits in an eight-entry memory that is read when the word is accepted
// and written back in the following cycle; a back-to-back sample of the same
// channel picks up the freshly written entry through a bypass. Results leave
// at one word per cycle while rsp_tready is high, from a four-group queue, so
// a sample that causes n events gives n result words. Input is held off while
// the queued groups plus a sample still in the update stage fill all four
// queue slots. Entry valid bits clear at reset, so no clearing pass is needed.
module power_reversal_event_timer (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // [3:0] direction_flags, [35:4] power_a, [67:36] power_b,
   // [99:68] power_c, [131:100] power_total, [135:132] zero
   input  logic [pret_pkg::REQ_DATA_W-1:0]  req_tdata,
   // [2:0] channel
   input  logic [pret_pkg::CHAN_W-1:0]      req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [2:0] event_channel, [4:3] event_phase, [5] reversed, [7:6] zero
   output logic [pret_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                             rsp_tlast,
   // [0] event_kind
   output logic [0:0]                       rsp_tuser,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [pret_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [pret_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [pret_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready
);
   import pret_pkg::*;

   // configuration
   logic [THRESH_W-1:0] threshold_ff;
   logic [HOLD_W-1:0]   hold_ff;
   logic                csr_write;

   // input side
   logic                req_fire;
   logic                present;
   logic [CH_IDX_W-1:0] rd_addr;
   logic [PHASES-1:0]   exceed;
   logic [POWER_W-1:0]  power;
   logic [POWER_W-1:0]  mag;

   // state memory
   pret_entry_type      entry_mem [CHANNELS];
   logic [CHANNELS-1:0] valid_ff;
   pret_entry_type      rd_data_ff;
   logic                rd_valid_ff;

   // update stage
   logic                s1_valid_ff;
   logic [CH_IDX_W-1:0] s1_addr_ff;
   logic [FLAGS_W-1:0]  s1_flags_ff;
   logic [PHASES-1:0]   s1_exceed_ff;

   // bypass of the last write
   logic                fw_valid_ff;
   logic [CH_IDX_W-1:0] fw_addr_ff;
   pret_entry_type      fw_entry_ff;

   pret_entry_type      cur_entry;
   pret_entry_type      new_entry;
   logic [FLAGS_W-1:0]  changed;
   logic [HOLD_W-1:0]   t;
   logic [PHASES-1:0]   fire;
   pret_group_type      group;
   logic                push;
   logic [QCNT_W-1:0]   q_count;

   // register port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESH_RESET;
         hold_ff      <= HOLD_RESET;
      end else if (csr_write) begin
         case (csr_paddr[2])
            REG_THRESHOLD: threshold_ff <= csr_pwdata[THRESH_W-1:0];
            REG_HOLD:      hold_ff      <= csr_pwdata[HOLD_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         REG_THRESHOLD: csr_prdata = CSR_DATA_W'(threshold_ff);
         REG_HOLD:      csr_prdata = CSR_DATA_W'(hold_ff);
         default:       csr_prdata = '0;
      endcase
   end

   // accept and compare magnitudes against the threshold
   assign req_tready = ((QCNT_W + 1)'(q_count) + (QCNT_W + 1)'(s1_valid_ff))
                       < (QCNT_W + 1)'(QUEUE_DEPTH);
   assign req_fire   = req_tvalid && req_tready;
   assign present    = int'(req_tuser) < CHANNELS;
   assign rd_addr    = CH_IDX_W'(req_tuser);

   always_comb begin
      exceed = '0;
      power  = '0;
      mag    = '0;
      for (int k = 0; k < PHASES; k++) begin
         power     = req_tdata[FLAGS_W + POWER_W*k +: POWER_W];
         mag       = power[POWER_W-1] ? (~power + POWER_W'(1)) : power;
         exceed[k] = mag > {1'b0, threshold_ff};
      end
   end

   // read the channel entry at accept
   always_ff @(posedge clock) begin
      if (req_fire && present) begin
         rd_data_ff  <= entry_mem[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
         s1_addr_ff  <= rd_addr;
         s1_flags_ff <= req_tdata[FLAGS_W-1:0];
         s1_exceed_ff <= exceed;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         fw_valid_ff <= 1'b0;
         valid_ff    <= '0;
      end else begin
         s1_valid_ff <= req_fire && present;
         fw_valid_ff <= s1_valid_ff;
         if (s1_valid_ff) begin
            valid_ff[s1_addr_ff] <= 1'b1;
         end
      end
   end

   // write back and hold a copy for the next sample
   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         entry_mem[s1_addr_ff] <= new_entry;
      end
      fw_addr_ff  <= s1_addr_ff;
      fw_entry_ff <= new_entry;
   end

   // load, count down and detect expiry
   always_comb begin
      if (fw_valid_ff && (fw_addr_ff == s1_addr_ff)) begin
         cur_entry = fw_entry_ff;
      end else if (rd_valid_ff) begin
         cur_entry = rd_data_ff;
      end else begin
         cur_entry = '0;
      end
      changed        = s1_flags_ff ^ cur_entry.prev;
      new_entry.prev = s1_flags_ff;
      new_entry.timer = '0;
      fire = '0;
      t    = '0;
      for (int k = 0; k < PHASES; k++) begin
         t = (changed[k] && s1_exceed_ff[k]) ? hold_ff : cur_entry.timer[k];
         new_entry.timer[k] = (t != '0) ? (t - HOLD_W'(1)) : '0;
         fire[k] = (t == HOLD_W'(1));
      end
      group.channel = CHAN_W'(s1_addr_ff);
      group.flags   = s1_flags_ff;
      group.fire    = fire;
      push = s1_valid_ff && (fire != '0);
   end

   pret_evq u_evq (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_group (group),
      .count      (q_count),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ===== rtl/core/pret_evq.sv =====
module pret_evq (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             push,
   input  pret_pkg::pret_group_type         push_group,
   output logic [pret_pkg::QCNT_W-1:0]      count,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [2:0] event_channel, [4:3] event_phase, [5] reversed, [7:6] zero
   output logic [pret_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                             rsp_tlast,
   // [0] event_kind
   output logic [0:0]                       rsp_tuser
);
   import pret_pkg::*;

   pret_group_type     groups_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff;
   logic [QPTR_W-1:0]  rd_ptr_ff;
   logic [QCNT_W-1:0]  count_ff;
   logic [QCNT_W-1:0]  count_in;

   pret_group_type     head;
   logic [PHASE_W-1:0] phase;
   logic [PHASES-1:0]  rest;
   logic               out_fire;
   logic               pop;

   // present the lowest pending event of the head group
   always_comb begin
      head       = groups_ff[rd_ptr_ff];
      phase      = first_phase(head.fire);
      rest       = head.fire & (head.fire - PHASES'(1));
      rsp_tvalid = (count_ff != '0);
      rsp_tlast  = (rest == '0);
      rsp_tuser  = (phase == PHASE_TOTAL) ? KIND_TOTAL : KIND_PHASE;
      rsp_tdata  = {2'b00, head.flags[phase], phase, head.channel};
      out_fire   = rsp_tvalid && rsp_tready;
      pop        = out_fire && rsp_tlast;
      count_in   = count_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   assign count = count_ff;

   // queue pointers and fill
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
      end
   end

   // store groups; drop the delivered phase from the head
   always_ff @(posedge clock) begin
      if (push) begin
         groups_ff[wr_ptr_ff] <= push_group;
      end
      if (out_fire && !rsp_tlast) begin
         groups_ff[rd_ptr_ff].fire <= rest;
      end
   end

endmodule

// ===== rtl/core/pret_checker.sv =====
module pret_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [pret_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input logic                             rsp_tlast,
   input logic [0:0]                       rsp_tuser
);
   import pret_pkg::*;

   // a stalled result word stays offered
   a_rsp_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result word dropped while stalled");

   // a stalled result word keeps its contents
   a_rsp_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tlast)
                                    && $stable(rsp_tuser))
      else $error("result word changed while stalled");

   // total events and only they carry the total kind
   a_kind_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser[0] == (rsp_tdata[4:3] == PHASE_TOTAL)))
      else $error("event kind does not match phase");

   // nothing pending right after reset
   a_reset_empty: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_tvalid)
      else $error("result offered right after reset");

endmodule

bind power_reversal_event_timer pret_checker u_pret_checker (.*);

// ===== tb/sv/power_reversal_event_timer_tb.sv =====
module power_reversal_event_timer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import pret_pkg::*;

   localparam int SETTLE_CYCLES   = 16;
   localparam int HOLD_OFF_CYCLES = 120;
   localparam int MAX_REPORTS     = 10;
   localparam logic [31:0] POWER_MIN = 32'h8000_0000;
   localparam logic [31:0] POWER_MAX = 32'h7fff_ffff;
   localparam logic [THRESH_W-1:0] THRESH_MAX = '1;

   // one per-second sample, power[0] is phase A, power[3] the total
   typedef struct packed {
      logic [CHAN_W-1:0]               channel;
      logic [FLAGS_W-1:0]              flags;
      logic [PHASES-1:0][POWER_W-1:0]  power;
   } meter_sample_type;

   typedef struct packed {
      logic [CHAN_W-1:0]  channel;
      logic               kind;
      logic [PHASE_W-1:0] phase;
      logic               reversed;
      logic               last_event;
   } reversal_event_type;

   logic                    clock       = 1'b0;
   logic                    reset       = 1'b1;
   logic                    req_tvalid  = 1'b0;
   logic                    req_tready;
   // [3:0] direction_flags, [35:4] power_a, [67:36] power_b,
   // [99:68] power_c, [131:100] power_total, [135:132] zero
   logic [REQ_DATA_W-1:0]   req_tdata   = '0;
   // [2:0] channel
   logic [CHAN_W-1:0]       req_tuser   = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready  = 1'b0;
   // [2:0] event_channel, [4:3] event_phase, [5] reversed, [7:6] zero
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic                    rsp_tlast;
   // [0] event_kind
   logic [0:0]              rsp_tuser;
   logic                    csr_psel    = 1'b0;
   logic                    csr_penable = 1'b0;
   logic                    csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0]   csr_paddr   = '0;
   logic [CSR_DATA_W-1:0]   csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0]   csr_prdata;
   logic                    csr_pready;

   power_reversal_event_timer DUT (.*);

   always #1 clock = ~clock;

   // predictor state and register copies
   logic [THRESH_W-1:0]     threshold  = THRESH_RESET;
   logic [HOLD_W-1:0]       hold_ticks = HOLD_RESET;
   logic [FLAGS_W-1:0]      prev_flags [CHANNELS];
   logic [HOLD_W-1:0]       hold_timer [CHANNELS][PHASES];

   meter_sample_type        pending_samples [$];
   reversal_event_type      expected_events [$];
   logic [FLAGS_W-1:0]      sent_flags [CHANNELS];

   int  pushed_count   = 0;
   int  accepted_count = 0;
   int  mismatches     = 0;
   logic req_accepted  = 1'b0;
   logic rsp_accepted  = 1'b0;
   bit  burst_mode     = 0;
   int  hold_off_asks  = 0;

   initial begin
      for (int c = 0; c < CHANNELS; c++) begin
         prev_flags[c] = '0;
         sent_flags[c] = '0;
         for (int k = 0; k < PHASES; k++) hold_timer[c][k] = '0;
      end
   end

   function automatic void flag_mismatch(input string what);
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
         $display("mismatch: %s", what);
      end
   endfunction

   // update channel state and queue the events this sample fires
   function automatic void predict_events(input logic [CHAN_W-1:0] ch,
                                          input logic [REQ_DATA_W-1:0] data);
      logic [FLAGS_W-1:0] flags;
      logic [FLAGS_W-1:0] changed;
      logic [POWER_W-1:0] pw;
      logic [POWER_W:0]   mag;
      reversal_event_type ev;
      reversal_event_type batch [$];
      flags = data[FLAGS_W-1:0];
      changed = flags ^ prev_flags[ch];
      prev_flags[ch] = flags;
      for (int k = 0; k < PHASES; k++) begin
         if (changed[k]) begin
            pw = data[FLAGS_W + POWER_W*k +: POWER_W];
            mag = pw[POWER_W-1] ? (33'h1_0000_0000 - {1'b0, pw}) : {1'b0, pw};
            if (mag > {2'b00, threshold}) hold_timer[ch][k] = hold_ticks;
         end
      end
      for (int k = 0; k < PHASES; k++) begin
         if (hold_timer[ch][k] != 0) begin
            hold_timer[ch][k] = hold_timer[ch][k] - 1'b1;
            if (hold_timer[ch][k] == 0) begin
               ev.channel    = ch;
               ev.phase      = PHASE_W'(k);
               ev.kind       = (ev.phase == PHASE_TOTAL) ? KIND_TOTAL : KIND_PHASE;
               ev.reversed   = flags[k];
               ev.last_event = 1'b0;
               batch.push_back(ev);
            end
         end
      end
      if (batch.size() != 0) batch[batch.size()-1].last_event = 1'b1;
      foreach (batch[i]) expected_events.push_back(batch[i]);
   endfunction

   // monitor: predict on accepted samples, check accepted event words
   always @(posedge clock) begin
      reversal_event_type exp_ev;
      reversal_event_type got;
      if (reset) begin
         req_accepted <= 1'b0;
         rsp_accepted <= 1'b0;
      end else begin
         req_accepted <= req_tvalid && req_tready;
         rsp_accepted <= rsp_tvalid && rsp_tready;
         if (req_tvalid && req_tready) begin
            accepted_count++;
            predict_events(req_tuser, req_tdata);
         end
         if (rsp_tvalid && rsp_tready) begin
            got.channel    = rsp_tdata[2:0];
            got.phase      = rsp_tdata[4:3];
            got.reversed   = rsp_tdata[5];
            got.kind       = rsp_tuser[0];
            got.last_event = rsp_tlast;
            if (expected_events.size() == 0) begin
               flag_mismatch($sformatf("unexpected event word ch=%0d phase=%0d kind=%0d",
                                       got.channel, got.phase, got.kind));
            end else begin
               exp_ev = expected_events.pop_front();
               if (got.channel != exp_ev.channel || got.phase != exp_ev.phase ||
                   got.kind != exp_ev.kind || got.reversed != exp_ev.reversed ||
                   got.last_event != exp_ev.last_event) begin
                  flag_mismatch($sformatf(
                     "exp ch=%0d kind=%0d phase=%0d rev=%0d last=%0d, got %0d %0d %0d %0d %0d",
                     exp_ev.channel, exp_ev.kind, exp_ev.phase, exp_ev.reversed,
                     exp_ev.last_event, got.channel, got.kind, got.phase, got.reversed,
                     got.last_event));
               end
            end
         end
      end
   end

   // sender: one sample per word, random gap before the next one
   int  gap_left = 0;
   bit  sender_eager = 0;
   meter_sample_type next_sample;
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         gap_left = 0;
      end else if (req_accepted || !req_tvalid) begin
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (pending_samples.size() != 0) begin
            next_sample = pending_samples.pop_front();
            req_tuser  <= next_sample.channel;
            req_tdata  <= {4'b0000, next_sample.power, next_sample.flags};
            req_tvalid <= 1'b1;
            if ($urandom_range(0, 11) == 0) sender_eager = !sender_eager;
            gap_left = (sender_eager || burst_mode) ? 0 : $urandom_range(0, 4);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver: random stall after each word, plus a long hold-off on request
   int  stall_left = 0;
   int  hold_off_left = 0;
   int  hold_off_served = 0;
   bit  receiver_eager = 0;
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (hold_off_served != hold_off_asks) begin
            hold_off_served++;
            hold_off_left = HOLD_OFF_CYCLES;
         end
         if (rsp_accepted) begin
            if ($urandom_range(0, 11) == 0) receiver_eager = !receiver_eager;
            stall_left = receiver_eager ? 0 : $urandom_range(0, 4);
         end
         if (hold_off_left > 0) begin
            hold_off_left--;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic push_sample(input logic [CHAN_W-1:0] ch, input logic [FLAGS_W-1:0] flags,
                              input logic [31:0] pa, input logic [31:0] pb,
                              input logic [31:0] pc, input logic [31:0] pt);
      meter_sample_type s;
      s.channel = ch;
      s.flags   = flags;
      s.power   = {pt, pc, pb, pa};
      sent_flags[ch] = flags;
      pending_samples.push_back(s);
      pushed_count++;
   endtask

   // wait until every sample is taken and every event has come back
   task automatic drain();
      while (accepted_count != pushed_count || expected_events.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(input logic reg_index, input logic [31:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= {reg_index, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (reg_index == REG_THRESHOLD) threshold = value[THRESH_W-1:0];
      else hold_ticks = value[HOLD_W-1:0];
   endtask

   task automatic configure(input logic [THRESH_W-1:0] thr, input logic [HOLD_W-1:0] hold);
      drain();
      write_register(REG_THRESHOLD, {1'b0, thr});
      write_register(REG_HOLD, {24'd0, hold});
      @(posedge clock);
   endtask

   // powers around the threshold, the extremes and plain random values
   function automatic logic [31:0] pick_power(input logic [THRESH_W-1:0] thr);
      case ($urandom_range(0, 9))
         0: return 32'd0;
         1: return {1'b0, thr};
         2: return {1'b0, thr} + 32'd1;
         3: return -{1'b0, thr};
         4: return -({1'b0, thr} + 32'd1);
         5: return POWER_MIN;
         6: return POWER_MAX;
         7: return 32'($urandom_range(0, 200)) - 32'd100;
         default: return $urandom;
      endcase
   endfunction

   // mostly repeat a couple of busy channels so timers run out
   task automatic push_random(input logic [THRESH_W-1:0] thr, input int count);
      logic [CHAN_W-1:0]  ch;
      logic [FLAGS_W-1:0] flags;
      repeat (count) begin
         ch = ($urandom_range(0, 3) == 0) ? CHAN_W'($urandom_range(0, 7))
                                          : CHAN_W'($urandom_range(0, 1));
         flags = ($urandom_range(0, 3) == 0) ? sent_flags[ch]
                                             : FLAGS_W'($urandom_range(0, 15));
         push_sample(ch, flags, pick_power(thr), pick_power(thr),
                     pick_power(thr), pick_power(thr));
      end
   endtask

   initial begin
      logic [THRESH_W-1:0] rnd_thr;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: magnitude at the threshold does not count, above it loads
      push_sample(3'd0, 4'hf, 32'd40, -32'd40, 32'd40, -32'd40);
      push_sample(3'd0, 4'h0, 32'd41, -32'd41, POWER_MIN, POWER_MAX);
      push_sample(3'd1, 4'h3, POWER_MAX, POWER_MIN, 32'd0, 32'd0);
      push_sample(3'd7, 4'h8, 32'd0, 32'd0, 32'd0, POWER_MIN);
      push_sample(3'd7, 4'h8, 32'd0, 32'd0, 32'd0, POWER_MIN);

      // zero threshold, one-tick hold: events on the same sample
      configure('0, 8'd1);
      push_sample(3'd2, 4'hf, 32'd1, -32'd1, POWER_MIN, POWER_MAX);
      push_sample(3'd2, 4'hf, 32'd1, -32'd1, POWER_MIN, POWER_MAX);
      push_sample(3'd2, 4'h0, 32'd0, 32'd0, 32'd0, 32'd0);
      push_sample(3'd2, 4'ha, 32'd0, 32'd1, 32'd0, 32'd1);
      push_sample(3'd3, 4'h1, 32'd5, 32'd0, 32'd0, 32'd0);
      push_sample(3'd4, 4'h8, 32'd0, 32'd0, 32'd0, -32'd7);

      // top threshold, zero hold: only the most negative power counts, no event
      configure(THRESH_MAX, 8'd0);
      push_sample(3'd4, 4'hf, POWER_MIN, POWER_MIN, POWER_MIN, POWER_MIN);
      push_sample(3'd4, 4'h0, POWER_MIN, POWER_MAX, POWER_MIN, POWER_MAX);

      // running timers survive small changes
      configure(THRESH_MAX, 8'd3);
      push_sample(3'd5, 4'hf, POWER_MAX, POWER_MIN, POWER_MAX, POWER_MIN);
      push_sample(3'd5, 4'hc, POWER_MAX, 32'd5, 32'd0, 32'd0);
      push_sample(3'd5, 4'hc, 32'd0, 32'd0, 32'd0, 32'd0);

      // random phases over several settings
      configure(31'd1000, 8'd2);
      push_random(31'd1000, 28);
      configure('0, 8'd1);
      push_random('0, 28);
      configure(31'd40, 8'd3);
      push_random(31'd40, 28);
      configure(THRESH_MAX, 8'd4);
      push_random(THRESH_MAX, 20);
      configure(31'd50, 8'd255);
      push_random(31'd50, 10);
      rnd_thr = THRESH_W'($urandom_range(0, 5000));
      configure(rnd_thr, HOLD_W'($urandom_range(1, 6)));
      push_random(rnd_thr, 28);

      // hold off the receiver while the sender keeps offering full event bursts
      configure('0, 8'd1);
      burst_mode = 1;
      hold_off_asks++;
      for (int i = 0; i < 16; i++) begin
         push_sample(3'd6, (i % 2 == 0) ? 4'hf : 4'h0,
                     32'd1000, -32'd1000, 32'd1000, -32'd1000);
      end
      drain();
      @(posedge clock);
      burst_mode = 0;

      drain();
      if (mismatches == 0 && expected_events.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // hard stop if the handshakes hang
   initial begin
      #200000;
      $display("Verification failed");
      $finish;
   end

endmodule
